// File: src/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants, codes and types of the bounded record list unit.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int CAPACITY   = 16;
  localparam int NAME_BYTES = 19;
  localparam int NAME_W     = NAME_BYTES * 8;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int SLOT_W     = $clog2(CAPACITY + 1);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 4;
  localparam int LEN_W      = 5;

  localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(CAPACITY);

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_REMOVE     = 2'd2;
  localparam logic [1:0] OP_SEARCH     = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [23:0]        name_high;
    logic signed [31:0] phone;
  } record_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PUSH_TAIL,
    ST_RM_STEP,
    ST_RM_FIX,
    ST_SR_STEP,
    ST_FINISH
  } state_t;

endpackage

// File: src/brl_req_if.sv
// ----------------------------------------------------------------------------
// brl_req_if
// Request channel: operation, position, name and phone with valid/ready.
// ----------------------------------------------------------------------------
interface brl_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         position;
  logic [63:0]        name_low;
  logic [63:0]        name_mid;
  logic [23:0]        name_high;
  logic signed [31:0] phone;

  modport source (output valid, op, position, name_low, name_mid, name_high, phone,
                  input ready);
  modport sink   (input valid, op, position, name_low, name_mid, name_high, phone,
                  output ready);
endinterface

// File: src/brl_rsp_if.sv
// ----------------------------------------------------------------------------
// brl_rsp_if
// Response channel: status, returned record and list length with valid/ready.
// ----------------------------------------------------------------------------
interface brl_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [63:0]        found_name_low;
  logic [63:0]        found_name_mid;
  logic [23:0]        found_name_high;
  logic signed [31:0] found_phone;
  logic [4:0]         list_length;

  modport source (output valid, status, found_name_low, found_name_mid,
                  found_name_high, found_phone, list_length, input ready);
  modport sink   (input valid, status, found_name_low, found_name_mid,
                  found_name_high, found_phone, list_length, output ready);
endinterface

// File: src/brl_record_store.sv
// ----------------------------------------------------------------------------
// brl_record_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module brl_record_store (
  input  logic            clk,
  input  logic            wr_en,
  input  brl_pkg::idx_t   wr_addr,
  input  brl_pkg::record_t wr_data,
  input  logic            rd_en,
  input  brl_pkg::idx_t   rd_addr,
  output brl_pkg::record_t rd_data
);
  import brl_pkg::*;

  record_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/bounded_record_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_record_list_unit
// Linked list of up to CAPACITY name/phone records kept in slot memories.
// ----------------------------------------------------------------------------
// Records sit in a record memory and a link memory, both with registered reads;
// unused slots form a free chain. One request is worked at a time and one
// response comes back per request. Each request has an accept step and a step
// loading the response register; between them a push writes the new slot, and
// a push back onto a non-empty list then links it from the old tail; remove at
// position p walks to the slot, then for p > 0 rewrites the previous link;
// search walks until a match or the list end; errors have nothing between.
// The walk through the link memory, one slot per cycle, sets the length of
// remove and search. The next request is taken while a response still waits.
module bounded_record_list_unit (
  input  logic clk,
  input  logic rst,
  brl_req_if.sink   req,
  brl_rsp_if.source rsp
);
  import brl_pkg::*;

  function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              ended;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      res[8*i +: 8] = ended ? 8'd0 : raw[8*i +: 8];
    end
    return res;
  endfunction

  state_t state, state_next;

  slot_t             head, tail, free_head;
  logic [CNT_W-1:0]  count;
  logic [1:0]        op_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  step;
  logic [NAME_W-1:0] key_r;
  logic signed [31:0] phone_r;
  slot_t             cur, prev, nxt_r;
  logic [1:0]        res_status;
  logic              res_found;

  logic               out_valid;
  logic [1:0]         out_status;
  record_t            out_rec;
  logic [LEN_W-1:0]   out_len;

  // link memory, with per-slot valid bits standing for the reset free chain
  slot_t               link_mem [CAPACITY];
  logic [CAPACITY-1:0] link_vld;
  slot_t               link_rdata;

  logic  lk_rd_en, lk_we, rec_rd_en, rec_we, out_load;
  idx_t  lk_raddr, lk_waddr, rec_raddr;
  slot_t lk_wdata;
  record_t rec_wdata, rec_rdata;

  logic accept, full, range_err, hit, match;

  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(CAPACITY)) || (free_head == NONE_SLOT);
  assign range_err = (CNT_W'(req.position) >= count) || (head == NONE_SLOT);
  assign hit       = (step == pos_r);
  assign match     = ({rec_rdata.name_high, rec_rdata.name_mid, rec_rdata.name_low}
                      == key_r);

  assign rec_wdata.name_low  = key_r[63:0];
  assign rec_wdata.name_mid  = key_r[127:64];
  assign rec_wdata.name_high = key_r[151:128];
  assign rec_wdata.phone     = phone_r;

  brl_record_store u_store (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (free_head[IDX_W-1:0]),
    .wr_data (rec_wdata),
    .rd_en   (rec_rd_en),
    .rd_addr (rec_raddr),
    .rd_data (rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (lk_we) begin
      link_vld[lk_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (lk_rd_en) begin
      link_rdata <= link_vld[lk_raddr] ? link_mem[lk_raddr]
                                       : SLOT_W'(lk_raddr) + SLOT_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: state_next = full ? ST_FINISH : ST_PUSH;
            OP_REMOVE:                   state_next = range_err ? ST_FINISH : ST_RM_STEP;
            default:                     state_next = (head == NONE_SLOT) ? ST_FINISH
                                                                          : ST_SR_STEP;
          endcase
        end
      end
      ST_PUSH: begin
        state_next = (op_r == OP_PUSH_BACK && tail != NONE_SLOT) ? ST_PUSH_TAIL
                                                                 : ST_FINISH;
      end
      ST_PUSH_TAIL: state_next = ST_FINISH;
      ST_RM_STEP: begin
        if (hit) begin
          state_next = (prev == NONE_SLOT) ? ST_FINISH : ST_RM_FIX;
        end
      end
      ST_RM_FIX: state_next = ST_FINISH;
      ST_SR_STEP: begin
        if (match || link_rdata == NONE_SLOT) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control and handshake
  always_comb begin
    req.ready = 1'b0;
    lk_rd_en  = 1'b0;
    lk_raddr  = head[IDX_W-1:0];
    lk_we     = 1'b0;
    lk_waddr  = free_head[IDX_W-1:0];
    lk_wdata  = NONE_SLOT;
    rec_rd_en = 1'b0;
    rec_raddr = head[IDX_W-1:0];
    rec_we    = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (accept) begin
          case (req.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              lk_rd_en = !full;
              lk_raddr = free_head[IDX_W-1:0];
            end
            OP_REMOVE: begin
              lk_rd_en  = !range_err;
              rec_rd_en = !range_err;
            end
            default: begin
              lk_rd_en  = (head != NONE_SLOT);
              rec_rd_en = (head != NONE_SLOT);
            end
          endcase
        end
      end
      ST_PUSH: begin
        rec_we   = 1'b1;
        lk_we    = 1'b1;
        lk_waddr = free_head[IDX_W-1:0];
        lk_wdata = (op_r == OP_PUSH_FRONT) ? head : NONE_SLOT;
      end
      ST_PUSH_TAIL: begin
        lk_we    = 1'b1;
        lk_waddr = tail[IDX_W-1:0];
        lk_wdata = cur;
      end
      ST_RM_STEP: begin
        if (hit) begin
          // removed slot goes to the front of the free chain
          lk_we    = 1'b1;
          lk_waddr = cur[IDX_W-1:0];
          lk_wdata = free_head;
        end else begin
          lk_rd_en  = 1'b1;
          lk_raddr  = link_rdata[IDX_W-1:0];
          rec_rd_en = 1'b1;
          rec_raddr = link_rdata[IDX_W-1:0];
        end
      end
      ST_RM_FIX: begin
        lk_we    = 1'b1;
        lk_waddr = prev[IDX_W-1:0];
        lk_wdata = nxt_r;
      end
      ST_SR_STEP: begin
        if (!match && link_rdata != NONE_SLOT) begin
          lk_rd_en  = 1'b1;
          lk_raddr  = link_rdata[IDX_W-1:0];
          rec_rd_en = 1'b1;
          rec_raddr = link_rdata[IDX_W-1:0];
        end
      end
      ST_FINISH: out_load = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= NONE_SLOT;
      tail      <= NONE_SLOT;
      free_head <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_PUSH: begin
          free_head <= link_rdata;
          count     <= count + CNT_W'(1);
          if (op_r == OP_PUSH_FRONT) begin
            head <= free_head;
            if (tail == NONE_SLOT) begin
              tail <= free_head;
            end
          end else if (tail == NONE_SLOT) begin
            head <= free_head;
            tail <= free_head;
          end
        end
        ST_PUSH_TAIL: tail <= cur;
        ST_RM_STEP: begin
          if (hit) begin
            free_head <= cur;
            count     <= count - CNT_W'(1);
            if (tail == cur) begin
              tail <= prev;
            end
            if (prev == NONE_SLOT) begin
              head <= link_rdata;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // request and walk registers, response payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_r      <= req.op;
          pos_r     <= req.position;
          key_r     <= normalize({req.name_high, req.name_mid, req.name_low});
          phone_r   <= req.phone;
          cur       <= head;
          prev      <= NONE_SLOT;
          step      <= '0;
          res_found <= 1'b0;
          case (req.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: res_status <= full ? STATUS_FULL : STATUS_OK;
            OP_REMOVE:                   res_status <= range_err ? STATUS_MISS : STATUS_OK;
            default:                     res_status <= STATUS_MISS;
          endcase
        end
      end
      ST_PUSH: cur <= free_head;
      ST_RM_STEP: begin
        if (hit) begin
          nxt_r     <= link_rdata;
          res_found <= 1'b1;
        end else begin
          prev <= cur;
          cur  <= link_rdata;
          step <= step + POS_W'(1);
        end
      end
      ST_SR_STEP: begin
        if (match) begin
          res_found  <= 1'b1;
          res_status <= STATUS_OK;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          out_status <= res_status;
          out_rec    <= res_found ? rec_rdata : '0;
          out_len    <= LEN_W'(count);
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.found_name_low  = out_rec.name_low;
  assign rsp.found_name_mid  = out_rec.name_mid;
  assign rsp.found_name_high = out_rec.name_high;
  assign rsp.found_phone     = out_rec.phone;
  assign rsp.list_length     = out_len;

endmodule

// File: sim/bounded_record_list_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_record_list_unit_tb
// Self-checking bench for the bounded record list unit. A queue-based model of
// the list predicts status, returned record and length for every request.
// Directed tests cover the empty and full list, name trimming, out-of-range
// removes and duplicate names. Random traffic then runs under several
// idle/stall mixes and one long response hold-off.
// ----------------------------------------------------------------------------
module bounded_record_list_unit_tb;
  import brl_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef logic [NAME_W-1:0] name_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [23:0]        name_high;
    logic signed [31:0] phone;
    logic [LEN_W-1:0]   length;
  } reply_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  logic clk = 1'b0;
  logic rst;

  brl_req_if req ();
  brl_rsp_if rsp ();

  bounded_record_list_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  record_t roster[$];
  reply_t  pending_replies[$];
  name_t   name_pool[6];
  int      error_count    = 0;
  int      reply_count    = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      hold_seq       = 0;

  task automatic report_error(input string msg);
    error_count++;
    $display("mismatch at %0t ns, response %0d: %s", $time, reply_count, msg);
  endtask

  // bytes after the first zero byte are dropped
  function automatic name_t trim_name(name_t n);
    bit ended;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (n[i*8 +: 8] == 8'h00) ended = 1'b1;
      if (ended) n[i*8 +: 8] = 8'h00;
    end
    return n;
  endfunction

  // random garbage behind the terminator, must not change the record
  function automatic name_t add_tail_noise(name_t n);
    bit ended;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (ended) n[i*8 +: 8] = 8'($urandom);
      else if (n[i*8 +: 8] == 8'h00) ended = 1'b1;
    end
    return n;
  endfunction

  function automatic name_t make_name(int len);
    name_t n;
    n = '0;
    for (int i = 0; i < len && i < NAME_BYTES; i++) n[i*8 +: 8] = 8'($urandom_range(1, 255));
    return n;
  endfunction

  function automatic name_t text_name(string s);
    name_t n;
    n = '0;
    for (int i = 0; i < s.len() && i < NAME_BYTES; i++) n[i*8 +: 8] = s[i];
    return n;
  endfunction

  task automatic predict_list_op(input logic [1:0] op, input logic [3:0] pos,
                                 input name_t name, input logic signed [31:0] phone,
                                 output reply_t r);
    name_t   key;
    record_t rec;
    bit      hit;
    key = trim_name(name);
    r   = '0;
    hit = 1'b0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (roster.size() >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          rec.name_low  = key[63:0];
          rec.name_mid  = key[127:64];
          rec.name_high = key[151:128];
          rec.phone     = phone;
          if (op == OP_PUSH_FRONT) roster.push_front(rec);
          else roster.push_back(rec);
          r.status = STATUS_OK;
        end
      end
      OP_REMOVE: begin
        if (int'(pos) >= roster.size()) begin
          r.status = STATUS_MISS;
        end else begin
          rec = roster[pos];
          roster.delete(int'(pos));
          r.status    = STATUS_OK;
          r.name_low  = rec.name_low;
          r.name_mid  = rec.name_mid;
          r.name_high = rec.name_high;
          r.phone     = rec.phone;
        end
      end
      default: begin
        r.status = STATUS_MISS;
        // first match from the head wins
        foreach (roster[i]) begin
          if (!hit && {roster[i].name_high, roster[i].name_mid, roster[i].name_low} == key) begin
            hit         = 1'b1;
            r.status    = STATUS_OK;
            r.name_low  = roster[i].name_low;
            r.name_mid  = roster[i].name_mid;
            r.name_high = roster[i].name_high;
            r.phone     = roster[i].phone;
          end
        end
      end
    endcase
    r.length = LEN_W'(roster.size());
  endtask

  // called at a rising edge; returns at the edge where the request transfers
  task automatic send_item(input logic [1:0] op, input logic [3:0] pos,
                           input name_t name, input logic signed [31:0] phone);
    reply_t want;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid     <= 1'b1;
    req.op        <= op;
    req.position  <= pos;
    req.name_low  <= name[63:0];
    req.name_mid  <= name[127:64];
    req.name_high <= name[151:128];
    req.phone     <= phone;
    do @(posedge clk); while (!req.ready);
    predict_list_op(op, pos, name, phone, want);
    pending_replies.push_back(want);
  endtask

  task automatic send_random_request(input traffic_mix_t mix);
    int                 roll;
    logic [1:0]         op;
    logic [3:0]         pos;
    name_t              name;
    logic signed [31:0] phone;
    record_t            rec;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  op = (roll < 35) ? OP_PUSH_FRONT : (roll < 70) ? OP_PUSH_BACK :
                      (roll < 80) ? OP_REMOVE : OP_SEARCH;
      MIX_DRAIN: op = (roll < 8) ? OP_PUSH_FRONT : (roll < 15) ? OP_PUSH_BACK :
                      (roll < 75) ? OP_REMOVE : OP_SEARCH;
      default:   op = (roll < 25) ? OP_PUSH_FRONT : (roll < 50) ? OP_PUSH_BACK :
                      (roll < 75) ? OP_REMOVE : OP_SEARCH;
    endcase

    pos = 4'($urandom);
    if (op == OP_REMOVE && roster.size() > 0 && $urandom_range(99) < 85)
      pos = 4'($urandom_range(roster.size() - 1));

    roll = $urandom_range(99);
    if (op == OP_SEARCH) begin
      if (roll < 55 && roster.size() > 0) begin
        rec  = roster[$urandom_range(roster.size() - 1)];
        name = {rec.name_high, rec.name_mid, rec.name_low};
      end else if (roll < 75) begin
        name = name_pool[$urandom_range(5)];
      end else begin
        name = make_name($urandom_range(NAME_BYTES));
      end
      if ($urandom_range(99) < 40) name = add_tail_noise(name);
    end else begin
      if (roll < 10) begin
        for (int i = 0; i < NAME_BYTES; i++) name[i*8 +: 8] = 8'($urandom);
      end else if (roll < 30) begin
        name = name_pool[$urandom_range(5)];
      end else begin
        name = make_name($urandom_range(NAME_BYTES));
      end
      if ($urandom_range(99) < 30) name = add_tail_noise(name);
    end

    case ($urandom_range(39))
      0:       phone = 32'sh8000_0000;
      1:       phone = 32'sh7fff_ffff;
      2:       phone = 32'sd0;
      3:       phone = -32'sd1;
      default: phone = $urandom;
    endcase

    send_item(op, pos, name, phone);
  endtask

  task automatic test_empty_list();
    send_item(OP_SEARCH, 4'd0, text_name("NOBODY"), 32'sd5);
    send_item(OP_REMOVE, 4'd0, '0, 32'sd0);
  endtask

  task automatic test_push_and_search();
    send_item(OP_PUSH_BACK, 4'd9, text_name("ALPHA"), 32'sh7fff_ffff);
    send_item(OP_PUSH_FRONT, 4'd15, {NAME_BYTES{8'hff}}, 32'sh8000_0000);
    send_item(OP_PUSH_BACK, 4'd0, add_tail_noise(text_name("BOB")), 32'sd0);
    // empty name, everything behind byte 0 is garbage
    send_item(OP_PUSH_FRONT, 4'd3, add_tail_noise('0), -32'sd1);
    send_item(OP_SEARCH, 4'd0, add_tail_noise(text_name("BOB")), 32'sd0);
    send_item(OP_SEARCH, 4'd0, {NAME_BYTES{8'hff}}, 32'sd0);
    send_item(OP_SEARCH, 4'd0, '0, 32'sd0);
  endtask

  task automatic test_remove();
    send_item(OP_REMOVE, 4'd15, '0, 32'sd0);
    send_item(OP_REMOVE, 4'd1, '0, 32'sd0);
    // duplicate name at the head shadows the older one
    send_item(OP_PUSH_FRONT, 4'd0, text_name("ALPHA"), 32'sd1);
    send_item(OP_SEARCH, 4'd0, text_name("ALPHA"), 32'sd0);
  endtask

  task automatic test_full_list();
    while (roster.size() < CAPACITY)
      send_item(OP_PUSH_FRONT, 4'($urandom), make_name($urandom_range(1, NAME_BYTES)), $urandom);
    send_item(OP_PUSH_BACK, 4'd0, text_name("OVERFLOW"), 32'sd7);
    send_item(OP_PUSH_FRONT, 4'd0, text_name("OVERFLOW"), 32'sd7);
    send_item(OP_REMOVE, 4'd15, '0, 32'sd0);
    send_item(OP_REMOVE, 4'd0, '0, 32'sd0);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    traffic_mix_t mix;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    mix = MIX_EVEN;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) mix = traffic_mix_t'($urandom_range(2));
      send_random_request(mix);
    end
  endtask

  // responses held off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq++;
    for (int i = 0; i < 40; i++) send_random_request(MIX_EVEN);
  endtask

  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        report_error("response transfer with no request outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (rsp.status !== want.status)
          report_error($sformatf("status: expected %0d, got %0d", want.status, rsp.status));
        if (rsp.found_name_low !== want.name_low)
          report_error($sformatf("found_name_low: expected %h, got %h",
                                 want.name_low, rsp.found_name_low));
        if (rsp.found_name_mid !== want.name_mid)
          report_error($sformatf("found_name_mid: expected %h, got %h",
                                 want.name_mid, rsp.found_name_mid));
        if (rsp.found_name_high !== want.name_high)
          report_error($sformatf("found_name_high: expected %h, got %h",
                                 want.name_high, rsp.found_name_high));
        if (rsp.found_phone !== want.phone)
          report_error($sformatf("found_phone: expected %0d, got %0d",
                                 want.phone, rsp.found_phone));
        if (rsp.list_length !== want.length)
          report_error($sformatf("list_length: expected %0d, got %0d",
                                 want.length, rsp.list_length));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d responses outstanding", pending_replies.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.op        <= OP_PUSH_FRONT;
    req.position  <= '0;
    req.name_low  <= '0;
    req.name_mid  <= '0;
    req.name_high <= '0;
    req.phone     <= '0;
    foreach (name_pool[i]) name_pool[i] = make_name($urandom_range(1, NAME_BYTES));
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_push_and_search();
    test_remove();
    test_full_list();
    test_random_traffic(0, 0, 460);
    test_random_traffic(74, 0, 460);
    test_random_traffic(0, 74, 460);
    test_random_traffic(28, 28, 470);
    test_backpressure();

    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: bounded_record_list_unit.f
src/brl_pkg.sv
src/brl_req_if.sv
src/brl_rsp_if.sv
src/brl_record_store.sv
src/bounded_record_list_unit.sv
sim/bounded_record_list_unit_tb.sv
